/* design/assert_macros.svh */
// Assertion macros shared by the RTL of the multichannel IIR filter.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/mciir_pkg.sv */
// Types and fixed constants of the multichannel IIR filter.
// No dependencies; imported by multichannel_iir_filter.
`default_nettype none

package mciir_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int COEF_W     = 18;
  localparam int STATE_W    = 48;
  localparam int PROD_W     = SAMPLE_W + COEF_W;
  localparam int ACC_W      = STATE_W + 2;
  localparam int MAX_CH     = 4;
  localparam int FRAC_SHIFT = 14;
  localparam int ROUND_HALF = 8192;
  localparam int SAMPLE_MAX = 32767;
  localparam int SAMPLE_MIN = -32768;
  localparam int CFG_IDX_W  = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_B0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_B1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_B2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_A1 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_A2 = 3'd4;

  localparam logic signed [COEF_W-1:0] B0_RESET = 18'sd16384;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef logic signed [PROD_W-1:0]   prod_t;
  typedef logic signed [STATE_W-1:0]  state_t;
  typedef logic signed [ACC_W-1:0]    acc_t;

endpackage

`default_nettype wire

/* design/multichannel_iir_filter.sv */
// Multichannel biquad (transposed direct form II), state held in a row-per-channel RAM.
// Depends on mciir_pkg and assert_macros.svh.
// A new input beat is taken only once the previous frame has been filtered for
// every channel and passed to the output register, so frames never overlap and
// a stalled output holds the block in its finishing step. Rate is set by the shared b/a
// multiplier pair and the read/modify/write of each channel's delay row.
// Reset (sync, rst_n low) restores the coefficients and marks every delay row
// as zero through per-row valid flags; no clearing pass is needed.
`default_nettype none
`include "assert_macros.svh"

module multichannel_iir_filter
  import mciir_pkg::*;
#(
  parameter int CHANNELS     = 4,
  parameter int FILTER_ORDER = 2
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // configuration write port
  input  logic                         cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [COEF_W-1:0]            cfg_wdata,
  // input frames
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [MAX_CH*SAMPLE_W-1:0]   in_tdata,   // sample_ch0, sample_ch1, sample_ch2, sample_ch3
  input  logic                         in_tuser,   // mono
  // filtered frames
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [MAX_CH*SAMPLE_W-1:0]   out_tdata,  // filtered_ch0 .. filtered_ch3
  output logic                         out_tuser   // clipped
);

  localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int TAP_W = (FILTER_ORDER > 1) ? $clog2(FILTER_ORDER) : 1;
  localparam logic [CH_W-1:0]  LAST_CH  = CH_W'(CHANNELS - 1);
  localparam logic [TAP_W-1:0] LAST_TAP = TAP_W'(FILTER_ORDER - 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_OUT  = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_ACC  = 3'd4;
  localparam logic [2:0] S_WB   = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;

  typedef state_t [FILTER_ORDER-1:0] row_t;

  // coefficients
  coef_t b0_r, b1_r, b2_r, a1_r, a2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b0_r <= B0_RESET;
      b1_r <= '0;
      b2_r <= '0;
      a1_r <= '0;
      a2_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_B0:  b0_r <= cfg_wdata;
        REG_B1:  b1_r <= cfg_wdata;
        REG_B2:  b2_r <= cfg_wdata;
        REG_A1:  a1_r <= cfg_wdata;
        REG_A2:  a2_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic [2:0]          state_r, state_nxt;
  logic [CH_W-1:0]     ch_r;
  logic [TAP_W-1:0]    tap_r;
  sample_t             smp_r [CHANNELS];
  logic                mono_r;
  sample_t             y_r;
  sample_t             yarr_r [CHANNELS];
  prod_t               pb_r, pa_r;
  logic                clip_r;
  logic [CHANNELS-1:0] valid_r;
  logic                rd_vld_r;
  row_t                rd_q_r, row_r;
  logic                out_tvalid_r;
  logic [MAX_CH*SAMPLE_W-1:0] out_tdata_r;
  logic                out_tuser_r;

  // delay-state RAM, one row per channel, registered read
  row_t dmem [CHANNELS];
  logic mem_rd, mem_we;

  assign mem_rd = (state_r == S_READ);
  assign mem_we = (state_r == S_WB);

  always_ff @(posedge clk) begin
    if (mem_rd) rd_q_r <= dmem[ch_r];
    if (mem_we) dmem[ch_r] <= row_r;
  end

  // datapath
  sample_t          x_cur;
  row_t             row_old;
  coef_t            cb_sel, ca_sel, mul_coef;
  prod_t            mul_b, mul_a;
  acc_t             acc_y, q_y, acc_z;
  sample_t          y_sat;
  logic             y_clip, z_clip;
  state_t           z_next, z_sat;
  logic [TAP_W-1:0] tap_nx;

  assign x_cur   = mono_r ? smp_r[0] : smp_r[ch_r];
  // a row never written since reset reads as zero
  assign row_old = rd_vld_r ? rd_q_r : '0;
  assign tap_nx  = tap_r + 1'b1;

  always_comb begin
    case (tap_r)
      TAP_W'(0): begin cb_sel = b1_r; ca_sel = a1_r; end
      TAP_W'(1): begin cb_sel = b2_r; ca_sel = a2_r; end
      default:   begin cb_sel = '0;   ca_sel = '0;   end
    endcase
  end

  assign mul_coef = (state_r == S_READ) ? b0_r : cb_sel;
  assign mul_b    = PROD_W'(mul_coef * x_cur);
  assign mul_a    = PROD_W'(ca_sel * y_r);

  // output: round z0 + b0*x from Q29 to Q15, saturate
  always_comb begin
    acc_y  = ACC_W'($signed(row_old[0])) + ACC_W'(pb_r) + ACC_W'(ROUND_HALF);
    q_y    = acc_y >>> FRAC_SHIFT;
    y_clip = 1'b0;
    if (q_y > ACC_W'(SAMPLE_MAX)) begin
      y_sat  = sample_t'(SAMPLE_MAX);
      y_clip = 1'b1;
    end else if (q_y < ACC_W'(SAMPLE_MIN)) begin
      y_sat  = sample_t'(SAMPLE_MIN);
      y_clip = 1'b1;
    end else begin
      y_sat  = q_y[SAMPLE_W-1:0];
    end
  end

  // state update: z[j] = z[j+1] + b*x - a*y, saturated to 48 bits
  always_comb begin
    if (FILTER_ORDER > 1 && tap_r != LAST_TAP) z_next = row_old[tap_nx];
    else                                       z_next = '0;
    acc_z  = ACC_W'(z_next) + ACC_W'(pb_r) - ACC_W'(pa_r);
    z_clip = (acc_z[ACC_W-1:STATE_W-1] != '0) && (acc_z[ACC_W-1:STATE_W-1] != '1);
    if (z_clip) z_sat = acc_z[ACC_W-1] ? {1'b1, {(STATE_W-1){1'b0}}}
                                       : {1'b0, {(STATE_W-1){1'b1}}};
    else        z_sat = acc_z[STATE_W-1:0];
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_tvalid) state_nxt = S_READ;
      S_READ: state_nxt = S_OUT;
      S_OUT:  state_nxt = S_MUL;
      S_MUL:  state_nxt = S_ACC;
      S_ACC:  state_nxt = (tap_r == LAST_TAP) ? S_WB : S_MUL;
      S_WB:   state_nxt = (ch_r == LAST_CH) ? S_FIN : S_READ;
      S_FIN:  if (!out_tvalid_r || out_tready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= '0;
      clip_r  <= 1'b0;
      ch_r    <= '0;
      tap_r   <= '0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        S_IDLE: begin
          ch_r   <= '0;
          clip_r <= 1'b0;
        end
        S_OUT: begin
          tap_r  <= '0;
          clip_r <= clip_r | y_clip;
        end
        S_ACC: begin
          tap_r  <= tap_nx;
          clip_r <= clip_r | z_clip;
        end
        S_WB: begin
          valid_r[ch_r] <= 1'b1;
          ch_r          <= ch_r + 1'b1;
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        for (int c = 0; c < CHANNELS; c++) begin
          smp_r[c] <= in_tdata[c*SAMPLE_W +: SAMPLE_W];
        end
        mono_r <= in_tuser;
      end
      S_READ: begin
        pb_r     <= mul_b;
        rd_vld_r <= valid_r[ch_r];
      end
      S_OUT: begin
        y_r          <= y_sat;
        yarr_r[ch_r] <= y_sat;
      end
      S_MUL: begin
        pb_r <= mul_b;
        pa_r <= mul_a;
      end
      S_ACC: row_r[tap_r] <= z_sat;
      default: ;
    endcase
  end

  // output register; unused channels read as zero
  logic [MAX_CH*SAMPLE_W-1:0] out_pack;

  for (genvar c = 0; c < MAX_CH; c++) begin : g_pack
    if (c < CHANNELS) begin : g_used
      assign out_pack[c*SAMPLE_W +: SAMPLE_W] = yarr_r[c];
    end else begin : g_unused
      assign out_pack[c*SAMPLE_W +: SAMPLE_W] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (state_r == S_FIN && (!out_tvalid_r || out_tready)) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_FIN && (!out_tvalid_r || out_tready)) begin
      out_tdata_r <= out_pack;
      out_tuser_r <= clip_r;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  // a beat taken always starts the per-channel walk at the first row
  `ASSERT_CLK(a_start, in_tvalid && in_tready |=> state_r == S_READ && ch_r == '0, "frame start lost")
  // results only appear from the finishing step
  `ASSERT_CLK(a_out_src, $rose(out_tvalid_r) |-> $past(state_r) == S_FIN, "unexpected output beat")
  // after a row is written back the walk moves on or finishes
  `ASSERT_CLK(a_wb_next, state_r == S_WB |=> state_r == S_READ || state_r == S_FIN, "bad step after write-back")
  // row valid flags are never cleared while out of reset
  `ASSERT_CLK(a_valid_mono, 1'b1 |=> (($past(valid_r) & ~valid_r) == '0), "row valid flag dropped")
  `ASSERT_ALWAYS(a_reset, !rst_n |=> state_r == S_IDLE && !out_tvalid_r && valid_r == '0, "reset state wrong")

endmodule

`default_nettype wire

/* test/testbench.sv */
// Self-checking bench for multichannel_iir_filter: random frames over several coefficient sets.
// A scoreboard class predicts each filtered frame and checks the result stream against it.
// Needs mciir_pkg and the multichannel_iir_filter RTL only.
`timescale 1ns / 100ps

module testbench;
  import mciir_pkg::*;

  localparam int  CHANNELS     = 4;
  localparam int  FILTER_ORDER = 2;
  localparam int  HALF_PERIOD  = 5;
  localparam int  DRAIN_CYCLES = CHANNELS * (3 + 2 * FILTER_ORDER) + 8;
  localparam int  LIMIT_CYCLES = 1_000_000;
  localparam longint STATE_HI  = (64'sd1 <<< (STATE_W - 1)) - 1;
  localparam longint STATE_LO  = -(64'sd1 <<< (STATE_W - 1));

  typedef struct {
    sample_t smp[MAX_CH];
    logic    mono;
  } frame_t;

  typedef struct {
    sample_t filt[MAX_CH];
    logic    clipped;
  } filtered_t;

  class iir_scoreboard;
    coef_t     ff[3];   // b0..b2
    coef_t     fb[3];   // a1, a2 at 1 and 2
    state_t    delay[CHANNELS * FILTER_ORDER];
    filtered_t expected_frames[$];
    int        errors;

    function new();
      ff[0] = B0_RESET;
      ff[1] = '0;
      ff[2] = '0;
      fb[0] = '0;
      fb[1] = '0;
      fb[2] = '0;
      foreach (delay[i]) delay[i] = '0;
      errors = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [COEF_W-1:0] val);
      case (idx)
        REG_B0: ff[0] = val;
        REG_B1: ff[1] = val;
        REG_B2: ff[2] = val;
        REG_A1: fb[1] = val;
        REG_A2: fb[2] = val;
        default: ;
      endcase
    endfunction

    function longint tap_ff(int k);
      return (k <= 2) ? longint'(ff[k]) : 64'sd0;
    endfunction

    function longint tap_fb(int k);
      return (k >= 1 && k <= 2) ? longint'(fb[k]) : 64'sd0;
    endfunction

    function int pending();
      return expected_frames.size();
    endfunction

    // advance every channel's section by one frame and queue the outputs
    function void note_frame(frame_t f);
      filtered_t r;
      longint    x, acc, y, nxt, v;
      logic      clip;
      int        base;
      clip = 1'b0;
      foreach (r.filt[c]) r.filt[c] = '0;
      for (int c = 0; c < CHANNELS && c < MAX_CH; c++) begin
        base = c * FILTER_ORDER;
        x = f.mono ? f.smp[0] : f.smp[c];
        acc = longint'(delay[base]) + tap_ff(0) * x;
        y = (acc + ROUND_HALF) >>> FRAC_SHIFT;
        if (y > SAMPLE_MAX) begin
          y = SAMPLE_MAX;
          clip = 1'b1;
        end else if (y < SAMPLE_MIN) begin
          y = SAMPLE_MIN;
          clip = 1'b1;
        end
        for (int j = 0; j < FILTER_ORDER; j++) begin
          nxt = (j + 1 < FILTER_ORDER) ? longint'(delay[base + j + 1]) : 64'sd0;
          v = nxt + tap_ff(j + 1) * x - tap_fb(j + 1) * y;
          if (v > STATE_HI) begin
            v = STATE_HI;
            clip = 1'b1;
          end else if (v < STATE_LO) begin
            v = STATE_LO;
            clip = 1'b1;
          end
          delay[base + j] = state_t'(v);
        end
        r.filt[c] = sample_t'(y);
      end
      r.clipped = clip;
      expected_frames.push_back(r);
    endfunction

    function void check_frame(logic [MAX_CH*SAMPLE_W-1:0] tdata, logic tuser);
      filtered_t exp_f;
      sample_t   got;
      if (expected_frames.size() == 0) begin
        $error("unexpected output beat: tdata %h tuser %b", tdata, tuser);
        errors++;
        return;
      end
      exp_f = expected_frames.pop_front();
      for (int c = 0; c < MAX_CH; c++) begin
        got = tdata[c*SAMPLE_W +: SAMPLE_W];
        if (got !== exp_f.filt[c]) begin
          $error("filtered_ch%0d: expected %0d, got %0d", c, exp_f.filt[c], got);
          errors++;
        end
      end
      if (tuser !== exp_f.clipped) begin
        $error("clipped: expected %0d, got %0d", exp_f.clipped, tuser);
        errors++;
      end
    endfunction
  endclass

  logic                       clk        = 1'b0;
  logic                       rst_n      = 1'b0;
  logic                       cfg_wr_en  = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_index  = '0;
  logic [COEF_W-1:0]          cfg_wdata  = '0;
  logic                       in_tvalid  = 1'b0;
  logic                       in_tready;
  logic [MAX_CH*SAMPLE_W-1:0] in_tdata   = '0;
  logic                       in_tuser   = 1'b0;
  logic                       out_tvalid;
  logic                       out_tready = 1'b0;
  logic [MAX_CH*SAMPLE_W-1:0] out_tdata;
  logic                       out_tuser;

  iir_scoreboard board;
  int            gap_pct    = 0;
  int            stall_pct  = 0;
  int            stall_left = 0;
  int            cycles     = 0;

  multichannel_iir_filter #(
    .CHANNELS     (CHANNELS),
    .FILTER_ORDER (FILTER_ORDER)
  ) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #HALF_PERIOD clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // result side back-pressure in bursts
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      out_tready <= 1'b0;
      stall_left <= $urandom_range(0, 18);
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) board.check_frame(out_tdata, out_tuser);
  end

  function automatic frame_t make_frame(int s0, int s1, int s2, int s3, bit mono);
    frame_t f;
    f.smp[0] = sample_t'(s0);
    f.smp[1] = sample_t'(s1);
    f.smp[2] = sample_t'(s2);
    f.smp[3] = sample_t'(s3);
    f.mono   = mono;
    return f;
  endfunction

  function automatic frame_t rand_frame();
    frame_t f;
    for (int c = 0; c < MAX_CH; c++) begin
      case ($urandom_range(0, 5))
        0:       f.smp[c] = sample_t'($urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN);
        1:       f.smp[c] = sample_t'(int'($urandom_range(0, 512)) - 256);
        2:       f.smp[c] = sample_t'(int'($urandom_range(0, 8192)) - 4096);
        default: f.smp[c] = sample_t'($urandom);
      endcase
    end
    f.mono = ($urandom_range(0, 3) == 0);
    return f;
  endfunction

  function automatic int rand_coef(bit modest);
    if (modest) return int'($urandom_range(0, 32767)) - 16384;
    return int'($urandom_range(0, 262143)) - 131072;
  endfunction

  task automatic send_frame(frame_t f);
    int gap;
    if ($urandom_range(0, 99) < gap_pct) begin
      gap = $urandom_range(1, 19);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    for (int c = 0; c < MAX_CH; c++) in_tdata[c*SAMPLE_W +: SAMPLE_W] <= f.smp[c];
    in_tuser  <= f.mono;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    board.note_frame(f);
  endtask

  // block is only reconfigured once every frame has come back
  task automatic settle();
    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic load_coefs(int b0, int b1, int b2, int a1, int a2, bit stray);
    logic [CFG_IDX_W-1:0] idx[5];
    int                   val[5];
    idx = '{REG_B0, REG_B1, REG_B2, REG_A1, REG_A2};
    val = '{b0, b1, b2, a1, a2};
    for (int k = 0; k < 5; k++) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= idx[k];
      cfg_wdata <= COEF_W'(val[k]);
      @(posedge clk);
      board.write_reg(idx[k], COEF_W'(val[k]));
    end
    // writes above the last register must leave the coefficients alone
    if (stray) begin
      for (int k = REG_A2 + 1; k < 2 ** CFG_IDX_W; k++) begin
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_IDX_W'(k);
        cfg_wdata <= COEF_W'($urandom);
        @(posedge clk);
        board.write_reg(CFG_IDX_W'(k), cfg_wdata);
      end
    end
    cfg_wr_en <= 1'b0;
  endtask

  task automatic run_random(int n);
    for (int i = 0; i < n; i++) send_frame(rand_frame());
    in_tvalid <= 1'b0;
  endtask

  initial begin
    board = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset coefficients pass samples straight through
    send_frame(make_frame(0, 0, 0, 0, 1'b0));
    send_frame(make_frame(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, 1'b0));
    send_frame(make_frame(SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN, 1'b0));
    send_frame(make_frame(SAMPLE_MAX, SAMPLE_MIN, -1, 1, 1'b0));
    send_frame(make_frame(-1, -1, -1, -1, 1'b0));
    send_frame(make_frame(16'h5555, 16'hAAAA, 16'h00FF, 16'hFF00, 1'b0));
    send_frame(make_frame(12345, -222, 3333, -4444, 1'b1));
    send_frame(make_frame(SAMPLE_MIN, SAMPLE_MAX, 7, -7, 1'b1));
    send_frame(make_frame(SAMPLE_MAX, 0, SAMPLE_MIN, 0, 1'b1));
    in_tvalid <= 1'b0;

    // stable low-pass with moderate idling
    settle();
    load_coefs(4096, 8192, 4096, -16384, 6554, 1'b0);
    gap_pct   = 20;
    stall_pct = 20;
    run_random(350);

    // all coefficients at the top: outputs and state saturate
    settle();
    load_coefs(131071, 131071, 131071, 131071, 131071, 1'b0);
    send_frame(make_frame(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, 1'b0));
    send_frame(make_frame(SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN, 1'b0));
    send_frame(make_frame(1, -1, 0, SAMPLE_MAX, 1'b1));
    run_random(150);

    // all coefficients at the bottom
    settle();
    load_coefs(-131072, -131072, -131072, -131072, -131072, 1'b0);
    gap_pct   = 0;
    stall_pct = 0;
    run_random(150);

    settle();
    load_coefs(rand_coef(0), rand_coef(0), rand_coef(0), rand_coef(0), rand_coef(0), 1'b0);
    gap_pct   = 40;
    stall_pct = 10;
    run_random(250);

    settle();
    load_coefs(rand_coef(1), rand_coef(1), rand_coef(1), rand_coef(1) / 2, rand_coef(1) / 4,
               1'b1);
    gap_pct   = 50;
    stall_pct = 50;
    run_random(400);

    // resonant high-pass, stray register writes, no idling to the end
    settle();
    load_coefs(16384, -32768, 16384, -29491, 13107, 1'b1);
    gap_pct   = 0;
    stall_pct = 0;
    run_random(600);

    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* multichannel_iir_filter.f */
+incdir+design
design/mciir_pkg.sv
design/multichannel_iir_filter.sv
test/testbench.sv
